// ===== sv/mdep_pkg.sv =====
// Shared types, character codes and calendar tables for the mail date parser.
// Used by mdep_front, mdep_queue, mdep_back and mail_date_to_epoch_parser.
package mdep_pkg;

  // Parsed-date queue between the character front end and the epoch back end
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic [13:0] EPOCH_YEAR = 14'd1970;
  localparam logic [13:0] BASE_YEAR  = 14'd1900;

  // One fully parsed date, handed from front to back
  typedef struct packed {
    logic               bad;
    logic [7:0]         day;
    logic [3:0]         month;
    logic [13:0]        year;
    logic [6:0]         hour;
    logic [6:0]         minute;
    logic [6:0]         second;
    logic signed [19:0] zone;
  } date_rec_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } month_hit_t;

  typedef struct packed {
    logic               hit;
    logic signed [19:0] secs;
  } zone_hit_t;

  // Look up a three-letter upper-case month name
  function automatic month_hit_t month_match(input logic [23:0] h);
    month_hit_t r;
    r.hit = 1'b1;
    case (h)
      "JAN": r.idx = 4'd0;
      "FEB": r.idx = 4'd1;
      "MAR": r.idx = 4'd2;
      "APR": r.idx = 4'd3;
      "MAY": r.idx = 4'd4;
      "JUN": r.idx = 4'd5;
      "JUL": r.idx = 4'd6;
      "AUG": r.idx = 4'd7;
      "SEP": r.idx = 4'd8;
      "OCT": r.idx = 4'd9;
      "NOV": r.idx = 4'd10;
      "DEC": r.idx = 4'd11;
      default: begin
        r.hit = 1'b0;
        r.idx = 4'd0;
      end
    endcase
    return r;
  endfunction

  // Named zones: seconds to add for UTC; unknown names starting C/E/M/P fail
  function automatic zone_hit_t zone_match(input logic [23:0] h);
    zone_hit_t r;
    r.hit = 1'b1;
    case (h)
      "CST": r.secs = 20'sd21600;
      "CDT": r.secs = 20'sd18000;
      "CET": r.secs = -20'sd3600;
      "CES": r.secs = -20'sd3600;
      "EST": r.secs = 20'sd18000;
      "EDT": r.secs = 20'sd14400;
      "EET": r.secs = -20'sd7200;
      "MST": r.secs = 20'sd25200;
      "MDT": r.secs = 20'sd21600;
      "MET": r.secs = -20'sd3600;
      "MEZ": r.secs = -20'sd3600;
      "PST": r.secs = 20'sd28800;
      "PDT": r.secs = 20'sd25200;
      default: begin
        r.secs = 20'sd0;
        r.hit  = !(h[23:16] == "C" || h[23:16] == "E" ||
                   h[23:16] == "M" || h[23:16] == "P");
      end
    endcase
    return r;
  endfunction

  // Weight of each numeric zone digit, in seconds
  function automatic logic [16:0] zone_weight(input logic [1:0] k);
    logic [16:0] w;
    case (k)
      2'd0:    w = 17'd36000;
      2'd1:    w = 17'd3600;
      2'd2:    w = 17'd600;
      default: w = 17'd60;
    endcase
    return w;
  endfunction

  // Days before the first of each month in a common year
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Days from the start of a four-year cycle to each of its years
  function automatic logic [10:0] cycle_days(input logic [1:0] r);
    logic [10:0] d;
    case (r)
      2'd1:    d = 11'd365;
      2'd2:    d = 11'd730;
      2'd3:    d = 11'd1096;
      default: d = 11'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== sv/mdep_front.sv =====
// Character front end: walks the date text one accepted character per cycle
// and emits one parsed date record on the final character. Depends on mdep_pkg.
module mdep_front import mdep_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] ch,
  input  logic       last,
  output logic       push,
  output date_rec_t  rec
);

  typedef enum logic [21:0] {
    P_LEAD  = 22'h000001,
    P_WDAY  = 22'h000002,
    P_WSP   = 22'h000004,
    P_WCSP  = 22'h000008,
    P_DAY   = 22'h000010,
    P_DSP   = 22'h000020,
    P_MON   = 22'h000040,
    P_MSP   = 22'h000080,
    P_YEAR  = 22'h000100,
    P_HSP   = 22'h000200,
    P_HOUR1 = 22'h000400,
    P_HOUR2 = 22'h000800,
    P_MIN0  = 22'h001000,
    P_MIN1  = 22'h002000,
    P_MIN2  = 22'h004000,
    P_SEC0  = 22'h008000,
    P_SEC1  = 22'h010000,
    P_SEC2  = 22'h020000,
    P_ZSP   = 22'h040000,
    P_ZNUM  = 22'h080000,
    P_ZNAME = 22'h100000,
    P_TAIL  = 22'h200000
  } phase_t;

  phase_t             phase, phase_next;
  logic [7:0]         day_acc, day_acc_next;
  logic [3:0]         month_idx, month_idx_next;
  logic [13:0]        year_acc, year_acc_next;
  logic [6:0]         hour_acc, hour_acc_next;
  logic [6:0]         minute_acc, minute_acc_next;
  logic [6:0]         second_acc, second_acc_next;
  logic [23:0]        letter_hold, letter_hold_next;
  logic [2:0]         digit_count, digit_count_next;
  logic signed [19:0] zone_secs, zone_secs_next;
  logic               failed, failed_next;

  logic               dig, upper, lower, letter;
  logic [3:0]         d;
  logic [7:0]         up;
  logic [11:0]        day_wide;
  logic signed [19:0] zone_sum;
  logic [18:0]        zone_add;
  month_hit_t         mh;
  zone_hit_t          zh;

  // Classify the character
  always_comb begin
    dig    = (ch >= "0") && (ch <= "9");
    upper  = (ch >= "A") && (ch <= "Z");
    lower  = (ch >= "a") && (ch <= "z");
    letter = upper || lower;
    d      = ch[3:0];
    up     = lower ? ch - 8'd32 : ch;
  end

  // Advance the parse by one character
  always_comb begin
    phase_next       = phase;
    day_acc_next     = day_acc;
    month_idx_next   = month_idx;
    year_acc_next    = year_acc;
    hour_acc_next    = hour_acc;
    minute_acc_next  = minute_acc;
    second_acc_next  = second_acc;
    letter_hold_next = letter_hold;
    digit_count_next = digit_count;
    zone_secs_next   = zone_secs;
    failed_next      = failed;
    day_wide         = 12'(day_acc * 10) + 12'(d);
    zone_add         = 19'(d * zone_weight(digit_count[1:0]));
    zone_sum         = zone_secs + signed'({1'b0, zone_add});
    mh               = month_match({letter_hold[15:0], up});
    zh               = zone_match({letter_hold[15:0], ch});
    if (!failed) begin
      case (phase)
        P_LEAD: begin
          if (ch == CH_SPACE) begin
          end else if (dig) begin
            day_acc_next = {4'd0, d};
            phase_next   = P_DAY;
          end else if (letter) begin
            digit_count_next = 3'd1;
            phase_next       = P_WDAY;
          end else failed_next = 1'b1;
        end
        P_WDAY: begin
          if (!letter) failed_next = 1'b1;
          else begin
            digit_count_next = digit_count + 3'd1;
            if (digit_count_next >= 3'd3) phase_next = P_WSP;
          end
        end
        P_WSP: begin
          if (ch == CH_SPACE) begin
          end else if (ch == CH_COMMA) phase_next = P_WCSP;
          else if (dig) begin
            day_acc_next = {4'd0, d};
            phase_next   = P_DAY;
          end else failed_next = 1'b1;
        end
        P_WCSP: begin
          if (ch == CH_SPACE) begin
          end else if (dig) begin
            day_acc_next = {4'd0, d};
            phase_next   = P_DAY;
          end else failed_next = 1'b1;
        end
        P_DAY: begin
          if (dig) day_acc_next = (day_wide > 12'd255) ? 8'd255 : day_wide[7:0];
          else if (ch == CH_SPACE) phase_next = P_DSP;
          else begin
            letter_hold_next = {16'd0, up};
            digit_count_next = 3'd1;
            phase_next       = P_MON;
          end
        end
        P_DSP: begin
          if (ch != CH_SPACE) begin
            letter_hold_next = {16'd0, up};
            digit_count_next = 3'd1;
            phase_next       = P_MON;
          end
        end
        P_MON: begin
          letter_hold_next = {letter_hold[15:0], up};
          digit_count_next = digit_count + 3'd1;
          if (digit_count_next >= 3'd3) begin
            if (mh.hit) begin
              month_idx_next = mh.idx;
              phase_next     = P_MSP;
            end else failed_next = 1'b1;
          end
        end
        P_MSP: begin
          if (ch == CH_SPACE) begin
          end else if (dig) begin
            year_acc_next    = {10'd0, d};
            digit_count_next = 3'd1;
            phase_next       = P_YEAR;
          end else failed_next = 1'b1;
        end
        P_YEAR: begin
          if (dig) begin
            year_acc_next    = 14'(year_acc * 10) + 14'(d);
            digit_count_next = digit_count + 3'd1;
            if (digit_count_next >= 3'd4) phase_next = P_HSP;
          end else if (digit_count == 3'd2 && ch == CH_SPACE) begin
            year_acc_next = year_acc + BASE_YEAR;
            phase_next    = P_HSP;
          end else failed_next = 1'b1;
        end
        P_HSP: begin
          if (ch == CH_SPACE) begin
          end else if (dig) begin
            hour_acc_next = {3'd0, d};
            phase_next    = P_HOUR1;
          end else failed_next = 1'b1;
        end
        P_HOUR1: begin
          if (dig) begin
            hour_acc_next = 7'(hour_acc * 10) + 7'(d);
            phase_next    = P_HOUR2;
          end else failed_next = 1'b1;
        end
        P_HOUR2: begin
          if (ch == CH_COLON) phase_next = P_MIN0;
          else failed_next = 1'b1;
        end
        P_MIN0: begin
          if (dig) begin
            minute_acc_next = {3'd0, d};
            phase_next      = P_MIN1;
          end else failed_next = 1'b1;
        end
        P_MIN1: begin
          if (dig) begin
            minute_acc_next = 7'(minute_acc * 10) + 7'(d);
            phase_next      = P_MIN2;
          end else failed_next = 1'b1;
        end
        P_MIN2: begin
          if (ch == CH_COLON) phase_next = P_SEC0;
          else if (ch == CH_SPACE) phase_next = P_ZSP;
          else failed_next = 1'b1;
        end
        P_SEC0: begin
          if (dig) begin
            second_acc_next = {3'd0, d};
            phase_next      = P_SEC1;
          end else failed_next = 1'b1;
        end
        P_SEC1: begin
          if (dig) begin
            second_acc_next = 7'(second_acc * 10) + 7'(d);
            phase_next      = P_SEC2;
          end else failed_next = 1'b1;
        end
        P_SEC2: begin
          if (ch == CH_SPACE) phase_next = P_ZSP;
          else failed_next = 1'b1;
        end
        P_ZSP: begin
          if (ch == CH_SPACE) begin
          end else if (ch == CH_PLUS || ch == CH_MINUS) begin
            letter_hold_next = {23'd0, ch == CH_PLUS};
            zone_secs_next   = 20'sd0;
            digit_count_next = 3'd0;
            phase_next       = P_ZNUM;
          end else if (upper) begin
            letter_hold_next = {16'd0, ch};
            digit_count_next = 3'd1;
            phase_next       = P_ZNAME;
          end else failed_next = 1'b1;
        end
        P_ZNUM: begin
          if (!dig) failed_next = 1'b1;
          else begin
            zone_secs_next   = zone_sum;
            digit_count_next = digit_count + 3'd1;
            if (digit_count_next >= 3'd4) begin
              if (letter_hold != 24'd0) zone_secs_next = -zone_sum;
              phase_next = P_TAIL;
            end
          end
        end
        P_ZNAME: begin
          if (!upper) failed_next = 1'b1;
          else begin
            letter_hold_next = {letter_hold[15:0], ch};
            digit_count_next = digit_count + 3'd1;
            if (digit_count_next >= 3'd3) begin
              zone_secs_next = zh.secs;
              if (zh.hit) phase_next = P_TAIL;
              else failed_next = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Build the record handed to the back end on the final character
  always_comb begin
    push       = accept && last;
    rec.bad    = failed_next || !(phase_next == P_MIN2 || phase_next == P_SEC2 ||
                                  phase_next == P_ZSP || phase_next == P_TAIL);
    rec.day    = day_acc_next;
    rec.month  = month_idx_next;
    rec.year   = year_acc_next;
    rec.hour   = hour_acc_next;
    rec.minute = minute_acc_next;
    rec.second = second_acc_next;
    rec.zone   = zone_secs_next;
  end

  // Hold state; return to start after the final character
  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      phase       <= P_LEAD;
      day_acc     <= '0;
      month_idx   <= '0;
      year_acc    <= '0;
      hour_acc    <= '0;
      minute_acc  <= '0;
      second_acc  <= '0;
      letter_hold <= '0;
      digit_count <= '0;
      zone_secs   <= '0;
      failed      <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      day_acc     <= day_acc_next;
      month_idx   <= month_idx_next;
      year_acc    <= year_acc_next;
      hour_acc    <= hour_acc_next;
      minute_acc  <= minute_acc_next;
      second_acc  <= second_acc_next;
      letter_hold <= letter_hold_next;
      digit_count <= digit_count_next;
      zone_secs   <= zone_secs_next;
      failed      <= failed_next;
    end
  end

endmodule

// ===== sv/mdep_queue.sv =====
// Small queue of parsed date records between front and back end.
// Depends on mdep_pkg for the record type and depth.
module mdep_queue import mdep_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  date_rec_t wdata,
  input  logic      pop,
  output logic      full,
  output logic      nonempty,
  output date_rec_t rdata
);

  date_rec_t      mem [QDepth];
  logic [QAw-1:0] wr_ptr, rd_ptr;
  logic [QAw:0]   count;

  assign full     = (count == (QAw+1)'(QDepth));
  assign nonempty = (count != '0);
  assign rdata    = mem[rd_ptr];

  // Store records
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> nonempty)
    else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
      push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");

endmodule

// ===== sv/mdep_back.sv =====
// Epoch back end: turns one parsed date record into seconds since 1970 UTC
// over a short sequence of multiply, add and shift steps. Depends on mdep_pkg.
module mdep_back import mdep_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_nonempty,
  input  date_rec_t        q_data,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [38:0]      out_seconds,
  output logic             out_bad
);

  typedef enum logic [5:0] {
    B_IDLE  = 6'b000001,
    B_PROD  = 6'b000010,
    B_DAYS  = 6'b000100,
    B_HOURS = 6'b001000,
    B_MINS  = 6'b010000,
    B_SECS  = 6'b100000
  } bstate_t;

  bstate_t            state;
  date_rec_t          rec;
  logic [12:0]        yoff;
  logic [21:0]        prod;
  logic signed [39:0] acc;
  logic               early;
  logic               out_free;
  logic [3:0]         mon;

  assign pop      = (state == B_IDLE) && q_nonempty;
  assign yoff     = 13'(rec.year - EPOCH_YEAR);
  assign early    = rec.year < EPOCH_YEAR;
  assign out_free = !out_valid || !out_stall;
  assign mon      = (rec.month < 4'd12) ? rec.month : 4'd0;

  // Sequence one record through the day and second arithmetic
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == B_SECS && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        B_IDLE: if (pop) state <= B_PROD;
        B_PROD: state <= B_DAYS;
        B_DAYS: state <= B_HOURS;
        B_HOURS: state <= B_MINS;
        B_MINS: state <= B_SECS;
        B_SECS: begin
          if (out_free) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // Datapath: whole cycles, days, then hours, minutes, seconds
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: if (pop) rec <= q_data;
      B_PROD: prod <= 22'(yoff[12:2]) * 22'd1461;
      B_DAYS: acc <= 40'(signed'({1'b0, prod}))
                   + 40'(signed'({1'b0, cycle_days(yoff[1:0])}))
                   + 40'(signed'({1'b0, (yoff[1:0] == 2'd2) && (mon > 4'd1)}))
                   + 40'(signed'({1'b0, days_before(mon)}))
                   + 40'(signed'({1'b0, rec.day})) - 40'sd1;
      B_HOURS: acc <= (acc <<< 4) + (acc <<< 3) + 40'(signed'({1'b0, rec.hour}));
      B_MINS:  acc <= (acc <<< 6) - (acc <<< 2) + 40'(signed'({1'b0, rec.minute}));
      B_SECS: begin
        if (out_free) begin
          out_bad <= rec.bad;
          if (rec.bad) out_seconds <= '0;
          else if (early) out_seconds <= 39'(rec.zone);
          else out_seconds <= 39'((acc <<< 6) - (acc <<< 2)
                                  + 40'(signed'({1'b0, rec.second})) + 40'(rec.zone));
        end
      end
      default: begin
      end
    endcase
  end

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
      out_valid && out_bad |-> out_seconds == '0)
    else $error("bad date carries nonzero seconds");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
      pop |=> state == B_PROD)
    else $error("record taken without starting arithmetic");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
      out_valid && out_stall |=> out_valid && $stable(out_seconds))
    else $error("stalled result changed");

endmodule

// ===== sv/mail_date_to_epoch_parser.sv =====
// Top level of the mail date parser: character front end, record queue and
// epoch back end. Depends on mdep_pkg, mdep_front, mdep_queue, mdep_back.
//
//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------
//  in      | in_valid / in_stall       | ch[7:0], last
//  out     | out_valid / out_stall     | seconds[38:0] (signed), bad
//
// One character is taken per cycle while the queue has room.
// A result passes through the queue and then five arithmetic steps after the
// final character of its date is taken, and the back end takes a new date only
// once it is back in idle after the last step, later while the output stalls.
// The queue holds four finished dates, so short bad dates back to back stall
// the input once the queue fills; real dates are longer than one date's steps.
// Synchronous reset returns the parser to its start and empties the queue.
// A stalled result holds in the output register while the back end waits.
module mail_date_to_epoch_parser import mdep_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         ch,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [38:0] seconds,
  output logic               bad
);

  logic      accept, push, pop, full, nonempty;
  date_rec_t wrec, rrec;
  logic [38:0] secs_raw;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;
  assign seconds  = signed'(secs_raw);

  mdep_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .ch     (ch),
    .last   (last),
    .push   (push),
    .rec    (wrec)
  );

  mdep_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (wrec),
    .pop      (pop),
    .full     (full),
    .nonempty (nonempty),
    .rdata    (rrec)
  );

  mdep_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_nonempty  (nonempty),
    .q_data      (rrec),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_seconds (secs_raw),
    .out_bad     (bad)
  );

endmodule

// ===== test/mail_date_to_epoch_parser_test.sv =====
// Testbench for the mail date parser: streams date text one character per item
// and checks each epoch result against a behavioral parser. Depends on mdep_pkg.
`timescale 1ns / 100ps

module mail_date_to_epoch_parser_test import mdep_pkg::*;;

  typedef enum logic [4:0] {
    PH_LEAD, PH_WDAY, PH_WSP, PH_WCSP, PH_DAY, PH_DSP, PH_MON, PH_MSP, PH_YEAR,
    PH_HSP, PH_HOUR1, PH_HOUR2, PH_MIN0, PH_MIN1, PH_MIN2, PH_SEC0, PH_SEC1,
    PH_SEC2, PH_ZSP, PH_ZNUM, PH_ZNAME, PH_TAIL
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  typedef struct packed {
    logic signed [38:0] secs;
    logic               bad;
  } epoch_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         ch = 8'h00;
  logic               last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [38:0] seconds;
  logic               bad;

  mail_date_to_epoch_parser dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .ch(ch),
    .last(last), .out_valid(out_valid), .out_stall(out_stall),
    .seconds(seconds), .bad(bad)
  );

  always #1 clk = ~clk;

  // Parser state of the predictor
  parse_phase_t phase;
  int unsigned  day_v, mon_v, year_v, hour_v, min_v, sec_v, hold_v, cnt_v;
  int           zone_v;
  bit           err_v;

  char_item_t pending_chars[$];
  epoch_t     expected_epochs[$];
  int         errors = 0;
  int         dates_seen = 0;
  int         bad_seen = 0;
  longint     cycle_count = 0;
  bit         pause_req = 1'b0;

  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_up(logic [7:0] c);
    return c >= "A" && c <= "Z";
  endfunction

  function automatic logic [7:0] to_up(logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic void clear_parse();
    phase = PH_LEAD;
    day_v = 0; mon_v = 0; year_v = 0; hour_v = 0; min_v = 0; sec_v = 0;
    hold_v = 0; cnt_v = 0; zone_v = 0; err_v = 0;
  endfunction

  function automatic int month_of(int unsigned h);
    string names;
    names = "JANFEBMARAPRMAYJUNJULAUGSEPOCTNOVDEC";
    for (int k = 0; k < 12; k++)
      if (h == {names[3*k], names[3*k+1], names[3*k+2]}) return k;
    return -1;
  endfunction

  // Zone offset in seconds; returns 0 in ok when the name is rejected
  function automatic int zone_of(int unsigned h, output bit ok);
    ok = 1;
    case (h[23:0])
      "CST", "MDT": return 21600;
      "CDT", "EST": return 18000;
      "CET", "CES", "MET", "MEZ": return -3600;
      "EDT": return 14400;
      "EET": return -7200;
      "MST", "PDT": return 25200;
      "PST": return 28800;
      default: begin
        ok = !(h[23:16] inside {"C", "E", "M", "P"});
        return 0;
      end
    endcase
  endfunction

  // Advance the predictor by one character
  function automatic void parse_char(logic [7:0] c);
    int unsigned d;
    bit dig, zok;
    int m, z;
    int weight[4];
    weight = '{36000, 3600, 600, 60};
    d = c - "0";
    dig = is_dig(c);
    if (err_v) return;
    case (phase)
      PH_LEAD:
        if (c != " ") begin
          if (dig) begin day_v = d; phase = PH_DAY; end
          else if (is_up(to_up(c))) begin cnt_v = 1; phase = PH_WDAY; end
          else err_v = 1;
        end
      PH_WDAY:
        if (!is_up(to_up(c))) err_v = 1;
        else begin cnt_v++; if (cnt_v >= 3) phase = PH_WSP; end
      PH_WSP:
        if (c != " ") begin
          if (c == ",") phase = PH_WCSP;
          else if (dig) begin day_v = d; phase = PH_DAY; end
          else err_v = 1;
        end
      PH_WCSP:
        if (c != " ") begin
          if (dig) begin day_v = d; phase = PH_DAY; end else err_v = 1;
        end
      PH_DAY:
        if (dig) day_v = (day_v * 10 + d > 255) ? 255 : day_v * 10 + d;
        else if (c == " ") phase = PH_DSP;
        else begin hold_v = to_up(c); cnt_v = 1; phase = PH_MON; end
      PH_DSP:
        if (c != " ") begin hold_v = to_up(c); cnt_v = 1; phase = PH_MON; end
      PH_MON: begin
        hold_v = ((hold_v << 8) | to_up(c)) & 24'hFFFFFF;
        cnt_v++;
        if (cnt_v >= 3) begin
          m = month_of(hold_v);
          if (m >= 0) begin mon_v = m; phase = PH_MSP; end else err_v = 1;
        end
      end
      PH_MSP:
        if (c != " ") begin
          if (dig) begin year_v = d; cnt_v = 1; phase = PH_YEAR; end else err_v = 1;
        end
      PH_YEAR:
        if (dig) begin
          year_v = year_v * 10 + d; cnt_v++;
          if (cnt_v >= 4) phase = PH_HSP;
        end else if (cnt_v == 2 && c == " ") begin
          year_v += 1900; phase = PH_HSP;
        end else err_v = 1;
      PH_HSP:
        if (c != " ") begin
          if (dig) begin hour_v = d; phase = PH_HOUR1; end else err_v = 1;
        end
      PH_HOUR1:
        if (dig) begin hour_v = hour_v * 10 + d; phase = PH_HOUR2; end else err_v = 1;
      PH_HOUR2: if (c == ":") phase = PH_MIN0; else err_v = 1;
      PH_MIN0: if (dig) begin min_v = d; phase = PH_MIN1; end else err_v = 1;
      PH_MIN1:
        if (dig) begin min_v = min_v * 10 + d; phase = PH_MIN2; end else err_v = 1;
      PH_MIN2:
        if (c == ":") phase = PH_SEC0;
        else if (c == " ") phase = PH_ZSP;
        else err_v = 1;
      PH_SEC0: if (dig) begin sec_v = d; phase = PH_SEC1; end else err_v = 1;
      PH_SEC1:
        if (dig) begin sec_v = sec_v * 10 + d; phase = PH_SEC2; end else err_v = 1;
      PH_SEC2: if (c == " ") phase = PH_ZSP; else err_v = 1;
      PH_ZSP:
        if (c != " ") begin
          if (c == "+" || c == "-") begin
            hold_v = (c == "+"); zone_v = 0; cnt_v = 0; phase = PH_ZNUM;
          end else if (is_up(c)) begin
            hold_v = c; cnt_v = 1; phase = PH_ZNAME;
          end else err_v = 1;
        end
      PH_ZNUM:
        if (!dig) err_v = 1;
        else begin
          zone_v += d * weight[cnt_v & 3];
          cnt_v++;
          if (cnt_v >= 4) begin
            if (hold_v != 0) zone_v = -zone_v;
            phase = PH_TAIL;
          end
        end
      PH_ZNAME:
        if (!is_up(c)) err_v = 1;
        else begin
          hold_v = ((hold_v << 8) | c) & 24'hFFFFFF;
          cnt_v++;
          if (cnt_v >= 3) begin
            z = zone_of(hold_v, zok);
            if (zok) begin zone_v = z; phase = PH_TAIL; end else err_v = 1;
          end
        end
      default: ;
    endcase
  endfunction

  // Seconds since 1970 from the parsed fields, zone excluded
  function automatic longint date_to_epoch();
    longint n, days;
    int days_tbl[12];
    int cyc[4];
    days_tbl = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    cyc = '{0, 365, 730, 1096};
    if (year_v < 1970) return 0;
    n = year_v - 1970;
    days = (n / 4) * 1461 + cyc[n % 4];
    if (n % 4 == 2 && mon_v > 1) days += 1;
    days += longint'(days_tbl[mon_v]) + longint'(day_v) - 1;
    return ((days * 24 + hour_v) * 60 + min_v) * 60 + sec_v;
  endfunction

  // Predict the result of one accepted character
  function automatic void predict_char(char_item_t it);
    epoch_t e;
    bit ok;
    parse_char(it.ch);
    if (!it.last) return;
    ok = !err_v && phase inside {PH_MIN2, PH_SEC2, PH_ZSP, PH_TAIL};
    e.secs = ok ? 39'(date_to_epoch() + zone_v) : '0;
    e.bad = !ok;
    expected_epochs.push_back(e);
    clear_parse();
  endfunction

  task automatic push_text(string s);
    char_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.ch = s[i];
      it.last = (i == s.len() - 1);
      pending_chars.push_back(it);
    end
  endtask

  // Queue text followed by a final NUL character
  task automatic push_text_nul(string s);
    char_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.ch = s[i];
      it.last = 1'b0;
      pending_chars.push_back(it);
    end
    it.ch = 8'h00;
    it.last = 1'b1;
    pending_chars.push_back(it);
  endtask

  function automatic string two_dig(int v);
    return $sformatf("%0d%0d", (v / 10) % 10, v % 10);
  endfunction

  // Build a mostly well-formed date with random content
  function automatic string random_date();
    string s, wd, mn, zn;
    string zones[15];
    string months;
    int m;
    zones = '{"CST", "CDT", "CET", "CES", "EST", "EDT", "EET", "MST", "MDT",
              "MET", "MEZ", "PST", "PDT", "UTC", "GMT"};
    months = "JanfebMARaprMayjunJulAUGsepOctnovDec";
    s = "";
    repeat ($urandom_range(0, 2)) s = {s, " "};
    if ($urandom_range(0, 1)) begin
      wd = "";
      repeat (3) wd = {wd, string'(8'($urandom_range(0, 1) ? $urandom_range(65, 90)
                                                             : $urandom_range(97, 122)))};
      s = {s, wd, $urandom_range(0, 1) ? ", " : " "};
    end
    s = {s, $sformatf("%0d", $urandom_range(0, 9) == 0 ? $urandom_range(0, 999)
                                                     : $urandom_range(1, 31))};
    m = $urandom_range(0, 11);
    mn = months.substr(3 * m, 3 * m + 2);
    s = {s, $urandom_range(0, 3) == 0 ? "" : " ", mn, " "};
    case ($urandom_range(0, 3))
      0: s = {s, two_dig($urandom_range(0, 99))};
      1: s = {s, $sformatf("%0d", $urandom_range(1000, 9999))};
      default: s = {s, $sformatf("%0d", $urandom_range(1965, 2106))};
    endcase
    s = {s, " ", two_dig($urandom_range(0, 99)), ":", two_dig($urandom_range(0, 99))};
    if ($urandom_range(0, 1)) s = {s, ":", two_dig($urandom_range(0, 99))};
    case ($urandom_range(0, 3))
      0: ;
      1: s = {s, " "};
      2: s = {s, " ", $urandom_range(0, 1) ? "+" : "-", two_dig($urandom_range(0, 99)),
              two_dig($urandom_range(0, 99))};
      default: begin
        zn = zones[$urandom_range(0, 14)];
        s = {s, " ", zn};
      end
    endcase
    if ($urandom_range(0, 5) == 0) s = {s, " tail"};
    // Corrupt one character in some dates, any byte value
    if ($urandom_range(0, 7) == 0) s[$urandom_range(0, s.len() - 1)] = 8'($urandom);
    return s;
  endfunction

  // Drive characters with random gaps; hold off when a pause is requested
  int gap_left = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_char(pending_chars.pop_front());
        gap_left = $urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : 0;
      end
      if (in_valid && in_stall) begin
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_chars.size() > 0 && !(pause_req && expected_epochs.size() > 0)) begin
        in_valid <= 1'b1;
        ch <= pending_chars[0].ch;
        last <= pending_chars[0].last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Check results and draw the receiver's stall
  int stall_left = 0;
  always @(posedge clk) begin
    epoch_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        dates_seen++;
        if (bad) bad_seen++;
        if (expected_epochs.size() == 0) begin
          errors++;
          $display("%0t: unexpected result seconds=%0d bad=%0b", $time, seconds, bad);
        end else begin
          e = expected_epochs.pop_front();
          if (seconds !== e.secs) begin
            errors++;
            $display("%0t: seconds expected %0d actual %0d", $time, e.secs, seconds);
          end
          if (bad !== e.bad) begin
            errors++;
            $display("%0t: bad expected %0b actual %0b", $time, e.bad, bad);
          end
        end
        stall_left = $urandom_range(0, 2) == 0 ? $urandom_range(0, 7) : 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Abort on a hung run
  always @(posedge clk) begin
    if (cycle_count > 400000) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    clear_parse();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // Directed dates: formats, zones, and the special cases
    push_text("Mon, 5 Jan 1996 12:34:56 EST");
    push_text("1 jan 1970 00:00");
    push_text("  Thu , 31 DEC 99 23:59:59 +1400");
    push_text("29 Feb 1972 10:00 -0930");
    push_text("1 Mar 2106 23:59:59 PDT tail text");
    push_text("0 Mar 1972 01:02 CET");
    push_text("0 Jan 1970 00:00");
    push_text("999 Jun 2000 12:00 UTC");
    push_text("15 Aug 1969 12:00 MEZ");
    push_text("3 Apr 196 12:00");
    push_text("3 Apr 19601 12:00");
    push_text("3 Apr 2001 12:00 XYZ");
    push_text("3 Apr 2001 12:00 CXT");
    push_text("3 Apr 2001 99:99:99 +99991");
    push_text("3 Foo 2001 12:00");
    push_text_nul("7 May 2001 12:00");
    push_text({8'hFF, "bad"});
    push_text("!");
    push_text("x");
    push_text("12May2001 12:00 MDT");
    while (pending_chars.size() > 0) @(posedge clk);
    // Hold the sender until all results have come back
    pause_req = 1'b1;
    while (expected_epochs.size() > 0 || in_valid) @(posedge clk);
    pause_req = 1'b0;
    // Random dates with occasional corruption
    for (int n = 0; n < 42; n++) begin
      push_text(random_date());
      if ($urandom_range(0, 9) == 0) push_text(string'(8'($urandom)));
    end
    while (pending_chars.size() > 0 || in_valid) @(posedge clk);
    while (expected_epochs.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Parsed %0d dates (%0d rejected) over directed and random text.",
             dates_seen, bad_seen);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
